### sv/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REC = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ln;
    logic [31:0] ld;
    logic [31:0] rn;
    logic [31:0] rd;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_PRE_RED, S_MUL1, S_MUL2, S_MUL3, S_RED, S_RED2,
    S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;
endpackage

### sv/rau_front.sv
`timescale 1ns / 1ps
module rau_front #(
  parameter int Depth = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::item_t in_item,
  output logic          q_valid,
  input  logic          q_pop,
  output rau_pkg::item_t q_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  rau_pkg::item_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic push;

  assign in_stall = (cnt == (AW+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (q_pop) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

### sv/rau_back.sv
`timescale 1ns / 1ps
module rau_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  rau_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    r_num,
  output logic [63:0]    r_den,
  output logic           r_eq,
  output logic           r_zd
);
  rau_pkg::state_t state, state_next;
  rau_pkg::item_t  it;
  logic [63:0] n, d, a, b, p1, p2;
  logic [1:0]  red_cnt;
  logic        ret;
  // divider
  logic [63:0] dq, dr, dv;
  logic [6:0]  dcnt;
  logic        dneg;

  logic [63:0] ln, ld, rn, rd, an, ad, div_rem_sh, rem;
  logic [64:0] trial;

  // operands fit in 33 signed bits, so the low 64 product bits come from a 33x33 multiply
  function automatic logic [63:0] mul33(logic [63:0] x, logic [63:0] y);
    logic signed [65:0] p;
    p = $signed(x[32:0]) * $signed(y[32:0]);
    return p[63:0];
  endfunction

  assign ln = {{32{it.ln[31]}}, it.ln};
  assign ld = {{32{it.ld[31]}}, it.ld};
  assign rn = {{32{it.rn[31]}}, it.rn};
  assign rd = {{32{it.rd[31]}}, it.rd};
  assign an = n[63] ? -n : n;
  assign ad = d[63] ? -d : d;
  assign div_rem_sh = {dr[62:0], dq[63]};
  assign trial = {dr, dq[63]} - {1'b0, dv};
  assign rem = trial[64] ? div_rem_sh : trial[63:0];

  assign q_pop = (state == rau_pkg::S_IDLE) && q_valid;
  assign out_valid = (state == rau_pkg::S_OUT);

  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::S_IDLE: if (q_valid) state_next = rau_pkg::S_PRE;
      rau_pkg::S_PRE: begin
        case (it.op)
          rau_pkg::OP_SUB: state_next = rau_pkg::S_RED;
          rau_pkg::OP_DIV: state_next = (rn == 64'd0) ? rau_pkg::S_OUT : rau_pkg::S_RED;
          rau_pkg::OP_REC: state_next = (ln == 64'd0) ? rau_pkg::S_OUT : rau_pkg::S_RED;
          rau_pkg::OP_ADD, rau_pkg::OP_MUL, rau_pkg::OP_CMP: state_next = rau_pkg::S_MUL1;
          default: state_next = rau_pkg::S_OUT;
        endcase
      end
      rau_pkg::S_PRE_RED: state_next = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1: state_next = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: begin
        if (it.op == rau_pkg::OP_CMP) state_next = rau_pkg::S_OUT;
        else if (it.op == rau_pkg::OP_MUL || it.op == rau_pkg::OP_DIV)
          state_next = rau_pkg::S_RED;
        else state_next = rau_pkg::S_MUL3;
      end
      rau_pkg::S_MUL3: state_next = rau_pkg::S_RED;
      rau_pkg::S_RED: state_next = (n == 64'd0) ? rau_pkg::S_RED2 : rau_pkg::S_GCD;
      rau_pkg::S_GCD: if (dcnt == 7'd0 && b == 64'd0) state_next = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN: if (dcnt == 7'd0) state_next = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD: if (dcnt == 7'd0) state_next = rau_pkg::S_RED2;
      rau_pkg::S_RED2: begin
        if (ret) state_next = rau_pkg::S_PRE_RED;
        else if (red_cnt > 2'd1) state_next = rau_pkg::S_RED;
        else state_next = rau_pkg::S_OUT;
      end
      rau_pkg::S_OUT: if (!out_stall) state_next = rau_pkg::S_IDLE;
      default: state_next = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rau_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      rau_pkg::S_IDLE: if (q_valid) it <= q_item;
      rau_pkg::S_PRE: begin
        r_eq <= 1'b0; r_num <= 64'd0; r_den <= 64'd1;
        r_zd <= (it.op == rau_pkg::OP_DIV && rn == 64'd0) ||
                (it.op == rau_pkg::OP_REC && ln == 64'd0);
        case (it.op)
          rau_pkg::OP_SUB: begin
            n <= -rn; d <= rd; ret <= 1'b1;
          end
          rau_pkg::OP_DIV: begin
            n <= rd; d <= rn; ret <= 1'b1;
          end
          rau_pkg::OP_REC: begin
            n <= ld; d <= ln; red_cnt <= 2'd1; ret <= 1'b0;
          end
          rau_pkg::OP_ADD, rau_pkg::OP_MUL, rau_pkg::OP_CMP: begin
            a <= rn; b <= rd;
          end
          default: ;
        endcase
      end
      rau_pkg::S_PRE_RED: begin
        a <= n; b <= d;
      end
      rau_pkg::S_MUL1: begin
        // b holds right den (or reduced), a right num
        if (it.op == rau_pkg::OP_MUL || it.op == rau_pkg::OP_DIV) begin
          p1 <= mul33(ln, a); p2 <= mul33(ld, b);
        end else begin
          p1 <= mul33(ln, b); p2 <= mul33(a, ld);
        end
      end
      rau_pkg::S_MUL2: begin
        if (it.op == rau_pkg::OP_CMP) begin
          r_eq <= (p1 == p2);
        end else if (it.op == rau_pkg::OP_MUL || it.op == rau_pkg::OP_DIV) begin
          n <= p1; d <= p2;
          red_cnt <= (it.op == rau_pkg::OP_DIV) ? 2'd2 : 2'd1;
          ret <= 1'b0;
        end else begin
          n <= p1 + p2; p2 <= mul33(ld, b);
        end
      end
      rau_pkg::S_MUL3: begin
        d <= p2; red_cnt <= 2'd1; ret <= 1'b0;
      end
      rau_pkg::S_RED: begin
        if (n == 64'd0) begin
          d <= 64'd1;
        end else begin
          if (n[63] && d[63]) begin n <= -n; d <= -d; end
          a <= an; b <= ad; dcnt <= 7'd0;
        end
      end
      rau_pkg::S_GCD: begin
        // a % b via restoring division, one bit per cycle
        if (dcnt == 7'd0) begin
          if (b == 64'd0) begin
            dv <= a; dq <= an; dr <= 64'd0; dneg <= n[63]; dcnt <= 7'd64;
          end else begin
            dq <= a; dr <= 64'd0; dv <= b; dcnt <= 7'd64;
          end
        end else begin
          dq <= {dq[62:0], ~trial[64]};
          dr <= rem;
          if (dcnt == 7'd1) begin
            a <= b; b <= rem;
          end
          dcnt <= dcnt - 7'd1;
        end
      end
      rau_pkg::S_DIVN: begin
        if (dcnt != 7'd0) begin
          dq <= {dq[62:0], ~trial[64]};
          dr <= rem;
          dcnt <= dcnt - 7'd1;
        end else begin
          n <= dneg ? -dq : dq;
          dq <= ad; dr <= 64'd0; dneg <= d[63]; dcnt <= 7'd64;
        end
      end
      rau_pkg::S_DIVD: begin
        if (dcnt != 7'd0) begin
          dq <= {dq[62:0], ~trial[64]};
          dr <= rem;
          dcnt <= dcnt - 7'd1;
        end else begin
          d <= dneg ? -dq : dq;
        end
      end
      rau_pkg::S_RED2: begin
        if (ret) begin
          ret <= 1'b0;
        end else if (red_cnt > 2'd1) begin
          red_cnt <= red_cnt - 2'd1;
        end else begin
          r_num <= n; r_den <= d;
        end
      end
      default: ;
    endcase
  end
endmodule

### sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// channel | handshake          | fields
// in      | in_valid/in_stall  | operation left_num left_den right_num right_den
// out     | out_valid/out_stall| result_num result_den is_equal zero_divide
// Zero divide and unused codes go from decode straight to output; compare passes
// the multiply states first; output stalls add wait. Each reduction runs a
// one-bit-per-cycle divider per Euclid step (up to about 93 on 64-bit magnitudes);
// a zero numerator skips it. Add, multiply and reciprocal reduce once, subtract
// twice, divide three times. Reset: synchronous, clears queue and sequencer. A
// two-entry queue accepts items while the sequencer works or waits on out_stall.
module rational_arithmetic_unit #(
  parameter int QueueDepth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [31:0] left_num,
  input  logic signed [31:0] left_den,
  input  logic signed [31:0] right_num,
  input  logic signed [31:0] right_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_num,
  output logic signed [63:0] result_den,
  output logic               is_equal,
  output logic               zero_divide
);
  rau_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;
  logic [63:0] rn, rd;

  assign in_item = '{op: operation, ln: left_num, ld: left_den,
                     rn: right_num, rd: right_den};

  rau_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_pop, .q_item
  );

  rau_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_item, .out_valid, .out_stall,
    .r_num(rn), .r_den(rd), .r_eq(is_equal), .r_zd(zero_divide)
  );

  assign result_num = rn;
  assign result_den = rd;
endmodule

### sv/rau_checker.sv
`timescale 1ns / 1ps
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_num,
  input logic [63:0] result_den,
  input logic        is_equal,
  input logic        zero_divide
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_num) &&
      $stable(result_den) && $stable(is_equal) && $stable(zero_divide))
    else $error("out item changed under stall");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_equal && zero_divide))
    else $error("both flags set");
  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |-> result_num == 64'd0 && result_den == 64'd1)
    else $error("compare result");
  a_zd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_divide |-> result_num == 64'd0 && result_den == 64'd1)
    else $error("zero divide result");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk, .rst, .out_valid, .out_stall, .result_num, .result_den,
  .is_equal, .zero_divide
);

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  typedef struct {
    logic [63:0] num;
    logic [63:0] den;
    logic        eq;
    logic        zd;
  } frac_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = '0;
  logic signed [31:0] left_num = '0;
  logic signed [31:0] left_den = '0;
  logic signed [31:0] right_num = '0;
  logic signed [31:0] right_den = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] result_num;
  logic signed [63:0] result_den;
  logic               is_equal;
  logic               zero_divide;

  frac_res_t   pending_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  localparam int QuietLimit = 400000;

  rational_arithmetic_unit dut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] div_mag(logic [63:0] v, logic [63:0] g);
    logic [63:0] m;
    m = mag64(v) / g;
    return v[63] ? (64'd0 - m) : m;
  endfunction

  function automatic void reduce_frac(inout logic [63:0] n, inout logic [63:0] d);
    logic [63:0] a, b, t;
    if (n == 0) begin
      d = 64'd1;
      return;
    end
    if (n[63] && d[63]) begin
      n = 64'd0 - n;
      d = 64'd0 - d;
    end
    a = mag64(n);
    b = mag64(d);
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    n = div_mag(n, a);
    d = div_mag(d, a);
  endfunction

  function automatic frac_res_t predict_frac(logic [2:0] op, logic [31:0] a32,
                                             logic [31:0] b32, logic [31:0] c32,
                                             logic [31:0] d32);
    frac_res_t r;
    logic [63:0] ln, ld, rn, rd, x, y;
    ln = {{32{a32[31]}}, a32};
    ld = {{32{b32[31]}}, b32};
    rn = {{32{c32[31]}}, c32};
    rd = {{32{d32[31]}}, d32};
    r.num = 64'd0;
    r.den = 64'd1;
    r.eq = 1'b0;
    r.zd = 1'b0;
    case (op)
      rau_pkg::OP_ADD: begin
        r.num = ln * rd + rn * ld;
        r.den = ld * rd;
        reduce_frac(r.num, r.den);
      end
      rau_pkg::OP_SUB: begin
        x = 64'd0 - rn;
        y = rd;
        reduce_frac(x, y);
        r.num = ln * y + x * ld;
        r.den = ld * y;
        reduce_frac(r.num, r.den);
      end
      rau_pkg::OP_MUL: begin
        r.num = ln * rn;
        r.den = ld * rd;
        reduce_frac(r.num, r.den);
      end
      rau_pkg::OP_DIV: begin
        if (rn == 0) begin
          r.zd = 1'b1;
        end else begin
          x = rd;
          y = rn;
          reduce_frac(x, y);
          r.num = ln * x;
          r.den = ld * y;
          reduce_frac(r.num, r.den);
          reduce_frac(r.num, r.den);
        end
      end
      rau_pkg::OP_REC: begin
        if (ln == 0) begin
          r.zd = 1'b1;
        end else begin
          r.num = ld;
          r.den = ln;
          reduce_frac(r.num, r.den);
        end
      end
      rau_pkg::OP_CMP: r.eq = (ln * rd == rn * ld);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation <= op;
    left_num <= a;
    left_den <= b;
    right_num <= c;
    right_den <= d;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_frac(op, a, b, c, d));
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3, 4: return $urandom;
      5: return $urandom_range(65535) - 32768;
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  task automatic test_directed();
    send_item(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_item(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(rau_pkg::OP_SUB, 3, 4, 3, 4);
    send_item(rau_pkg::OP_SUB, 32'h8000_0000, 1, 32'h8000_0000, 32'hffff_ffff);
    send_item(rau_pkg::OP_MUL, -6, -8, -4, -3);
    send_item(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(rau_pkg::OP_MUL, 0, 5, 7, 9);
    send_item(rau_pkg::OP_DIV, 1, 2, 0, 5);
    send_item(rau_pkg::OP_DIV, 5, -6, -10, 3);
    send_item(rau_pkg::OP_DIV, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_item(rau_pkg::OP_REC, 0, 7, 1, 1);
    send_item(rau_pkg::OP_REC, -4, -10, 0, 0);
    send_item(rau_pkg::OP_REC, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send_item(rau_pkg::OP_CMP, 1, 2, 2, 4);
    send_item(rau_pkg::OP_CMP, 1, 2, 2, 5);
    send_item(rau_pkg::OP_CMP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(3'd6, 1, 2, 3, 4);
    send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(rau_pkg::OP_ADD, 3, 0, 5, 0);
    send_item(rau_pkg::OP_MUL, -7, 0, 1, 1);
    send_item(rau_pkg::OP_ADD, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_item(op, pick_val(), pick_val(), pick_val(), pick_val());
    end
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    frac_res_t e;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: num=%h den=%h", result_num, result_den);
        end else begin
          e = pending_q.pop_front();
          if (result_num !== e.num || result_den !== e.den ||
              is_equal !== e.eq || zero_divide !== e.zd) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%h eq=%b zd=%b got %h/%h eq=%b zd=%b",
                       e.num, e.den, e.eq, e.zd, result_num, result_den, is_equal,
                       zero_divide);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 10;
    recv_idle_pct = 62;
    test_random(260);
    test_drain_pause();
    send_idle_pct = 62;
    recv_idle_pct = 10;
    test_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(260);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
